// ===== hw/rtl/pcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pcr_pkg;

	localparam int unsigned ROUNDS = 10;

	localparam logic [31:0] MUL_A  = 32'hD2511F53;
	localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
	localparam logic [31:0] WEYL_A = 32'h9E3779B9;
	localparam logic [31:0] WEYL_B = 32'hBB67AE85;

	localparam int unsigned CNT_W = 3;
	localparam logic [CNT_W-1:0] MAX_KEPT = 3'd4;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 64;

	typedef enum logic {
		REG_KEY_SEED      = 1'b0,
		REG_COUNTER_START = 1'b1
	} reg_idx_t;

	// one counter block in flight, with the key for its round
	typedef struct packed {
		logic [CNT_W-1:0] kept;
		logic [31:0]      ka;
		logic [31:0]      kb;
		logic [31:0]      x3;
		logic [31:0]      x2;
		logic [31:0]      x1;
		logic [31:0]      x0;
	} blk_t;

	typedef struct packed {
		logic [63:0] key_seed;
		logic [63:0] counter_start;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pcr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcr_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pcr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pcr_pkg::DATA_W-1:0]  pwdata,
	output logic      [pcr_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output pcr_pkg::cfg_t                    cfg
);

	logic [63:0]       key_seed_q;
	logic [63:0]       counter_start_q;
	pcr_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = pcr_pkg::reg_idx_t'(paddr[3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q      <= '0;
			counter_start_q <= '0;
		end else if (wr_en) begin
			case (idx)
				pcr_pkg::REG_KEY_SEED:      key_seed_q      <= pwdata;
				pcr_pkg::REG_COUNTER_START: counter_start_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pcr_pkg::REG_KEY_SEED:      prdata = key_seed_q;
			pcr_pkg::REG_COUNTER_START: prdata = counter_start_q;
			default:                    prdata = '0;
		endcase
	end

	assign cfg.key_seed      = key_seed_q;
	assign cfg.counter_start = counter_start_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pcr_round_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcr_round_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire pcr_pkg::blk_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output pcr_pkg::blk_t     out_data
);

	logic          v_q;
	pcr_pkg::blk_t d_q;
	pcr_pkg::blk_t nxt;
	logic [63:0]   pa;
	logic [63:0]   pb;

	assign in_ready = !v_q || out_ready;

	assign pa = {32'd0, pcr_pkg::MUL_A} * {32'd0, in_data.x0};
	assign pb = {32'd0, pcr_pkg::MUL_B} * {32'd0, in_data.x2};

	always_comb begin
		nxt.x0   = pb[63:32] ^ in_data.x1 ^ in_data.ka;
		nxt.x1   = pb[31:0];
		nxt.x2   = pa[63:32] ^ in_data.x3 ^ in_data.kb;
		nxt.x3   = pa[31:0];
		// key for the next round
		nxt.ka   = in_data.ka + pcr_pkg::WEYL_A;
		nxt.kb   = in_data.kb + pcr_pkg::WEYL_B;
		nxt.kept = in_data.kept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule
`default_nettype wire

// ===== hw/rtl/philox_counter_rng.sv =====
// Philox-4x32 counter-based random block generator.
// Configure key_seed (byte address 0) and counter_start (byte address 8) over
// the APB port while the block is idle; both reset to zero.
// Input stream s_*: each word carries a block offset and a wanted count. The
// counter block is (ctr low, ctr high, 0, 0) with ctr = counter_start + offset.
// Output stream m_*: the four mixed words and the kept count (saturated at 4).
// Path: a word accepted on s_* is registered in one load stage for the 64-bit
// counter add, then in one cell per round, before it appears on m_tvalid.
// Throughput: one word per cycle while m_tready is high; each round cell holds
// one block and hands it on every cycle unless the stage after it stalls.
// When the receiver stalls, cells fill up from the output end; bubbles are
// squeezed out and s_tready drops only once every stage is occupied.
// Reset clears all valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module philox_counter_rng (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pcr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pcr_pkg::DATA_W-1:0]  pwdata,
	output logic      [pcr_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [39:0]                 s_tdata,   // block_offset, words_wanted
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [135:0]                m_tdata    // word_zero .. word_three, words_kept
);

	pcr_pkg::cfg_t cfg;

	logic                      ld_v_s1;
	pcr_pkg::blk_t             ld_d_s1;
	logic                      ld_rdy;
	logic [63:0]               ctr;
	logic [pcr_pkg::CNT_W-1:0] want;

	logic          c_valid [0:pcr_pkg::ROUNDS];
	logic          c_ready [0:pcr_pkg::ROUNDS];
	pcr_pkg::blk_t c_data  [0:pcr_pkg::ROUNDS];

	pcr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign ctr  = cfg.counter_start + {32'd0, s_tdata[31:0]};
	assign want = s_tdata[34:32];

	assign ld_rdy   = !ld_v_s1 || c_ready[0];
	assign s_tready = ld_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
		end else if (ld_rdy) begin
			ld_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_rdy && s_tvalid) begin
			ld_d_s1.x0   <= ctr[31:0];
			ld_d_s1.x1   <= ctr[63:32];
			ld_d_s1.x2   <= '0;
			ld_d_s1.x3   <= '0;
			ld_d_s1.ka   <= cfg.key_seed[31:0];
			ld_d_s1.kb   <= cfg.key_seed[63:32];
			ld_d_s1.kept <= (want > pcr_pkg::MAX_KEPT) ? pcr_pkg::MAX_KEPT : want;
		end
	end

	assign c_valid[0] = ld_v_s1;
	assign c_data[0]  = ld_d_s1;

	for (genvar i = 0; i < pcr_pkg::ROUNDS; i++) begin : g_round
		pcr_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_data   (c_data[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_data  (c_data[i+1])
		);
	end

	assign m_tvalid                   = c_valid[pcr_pkg::ROUNDS];
	assign c_ready[pcr_pkg::ROUNDS]   = m_tready;
	assign m_tdata = {5'd0,
		c_data[pcr_pkg::ROUNDS].kept,
		c_data[pcr_pkg::ROUNDS].x3,
		c_data[pcr_pkg::ROUNDS].x2,
		c_data[pcr_pkg::ROUNDS].x1,
		c_data[pcr_pkg::ROUNDS].x0};

`ifndef SYNTHESIS
	a_kept_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[130:128] <= pcr_pkg::MAX_KEPT))
		else $error("words_kept above four");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		!ld_v_s1 |-> s_tready)
		else $error("input stalled with empty load stage");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && !paddr[3]) |=> (cfg.key_seed == $past(pwdata)))
		else $error("key_seed write lost");
`endif

endmodule
`default_nettype wire
